/* rtl/core/mnee_pkg.sv */
package mnee_pkg;

    localparam int MAX_DELTA_BYTES = 4;
    localparam int VAL_W           = 28;
    localparam int VLQ_W           = 7 * MAX_DELTA_BYTES;
    localparam int CNT_W           = $clog2(MAX_DELTA_BYTES + 1);
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    localparam logic [3:0] DRUM_IN_CH   = 4'd3;
    localparam logic [3:0] DRUM_OUT_CH  = 4'd9;
    localparam logic [7:0] ST_PROGRAM   = 8'hC0;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] VEL_ON       = 8'd100;
    localparam logic [7:0] VEL_OFF      = 8'd0;
    localparam logic [7:0] ZERO_DELTA   = 8'h00;

    typedef struct packed {
        logic [7:0]       note;
        logic [VAL_W-1:0] note_length;
        logic [VAL_W-1:0] delay_before;
        logic             first_note;
        logic [3:0]       channel;
        logic [7:0]       instrument;
    } note_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } note_rsp_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [VAL_W-1:0] dly;
        logic [CNT_W-1:0] dly_n;
        logic [VAL_W-1:0] len;
        logic [CNT_W-1:0] len_n;
        logic             first;
        logic [7:0]       pc_status;
        logic [7:0]       on_status;
        logic [7:0]       instrument;
        logic [7:0]       note;
    } mnee_cmd_t;

    // number of 7-bit groups, at least one
    function automatic logic [CNT_W-1:0] vlq_count(logic [VAL_W-1:0] v);
        logic [VLQ_W-1:0] e;
        logic [CNT_W-1:0] n;
        e = VLQ_W'(v);
        n = CNT_W'(1);
        for (int k = 1; k < MAX_DELTA_BYTES; k++)
        begin
            if ((e >> (7 * k)) != '0)
                n = CNT_W'(k + 1);
        end
        return n;
    endfunction

    // byte i of an n-group quantity, most significant group first
    function automatic logic [7:0] vlq_byte(logic [VAL_W-1:0] v, logic [CNT_W-1:0] n,
                                            logic [CNT_W-1:0] i);
        logic [VLQ_W-1:0] e;
        logic [6:0]       g;
        int               sel;
        e   = VLQ_W'(v);
        g   = '0;
        sel = int'(n) - 1 - int'(i);
        for (int k = 0; k < MAX_DELTA_BYTES; k++)
        begin
            if (k == sel)
                g = e[7*k +: 7];
        end
        return {(i != n - CNT_W'(1)), g};
    endfunction

endpackage

/* rtl/core/mnee_front.sv */
module mnee_front (
    input  mnee_pkg::note_req_t req,
    output mnee_pkg::mnee_cmd_t cmd
);
    import mnee_pkg::*;

    logic drum;

    assign drum = (req.channel == DRUM_IN_CH);

    always_comb
    begin
        cmd.dly        = req.delay_before;
        cmd.dly_n      = vlq_count(req.delay_before);
        cmd.len        = req.note_length;
        cmd.len_n      = vlq_count(req.note_length);
        cmd.first      = req.first_note;
        cmd.pc_status  = ST_PROGRAM | {4'd0, drum ? DRUM_OUT_CH : req.channel};
        cmd.on_status  = ST_NOTE_ON | {4'd0, drum ? DRUM_OUT_CH : req.channel};
        cmd.instrument = req.instrument;
        cmd.note       = req.note;
    end

endmodule

/* rtl/core/mnee_queue.sv */
module mnee_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mnee_pkg::mnee_cmd_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output mnee_pkg::mnee_cmd_t rd_data,
    output logic                empty
);
    import mnee_pkg::*;

    mnee_cmd_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/core/mnee_back.sv */
module mnee_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mnee_pkg::mnee_cmd_t cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output mnee_pkg::note_rsp_t rsp,
    output logic                empty,
    input  logic                pop
);
    import mnee_pkg::*;

    localparam logic [3:0] PH_DLY  = 4'd0;
    localparam logic [3:0] PH_PC   = 4'd1;
    localparam logic [3:0] PH_INST = 4'd2;
    localparam logic [3:0] PH_ZERO = 4'd3;
    localparam logic [3:0] PH_NON  = 4'd4;
    localparam logic [3:0] PH_NOTE = 4'd5;
    localparam logic [3:0] PH_VEL  = 4'd6;
    localparam logic [3:0] PH_LEN  = 4'd7;
    localparam logic [3:0] PH_NOFF = 4'd8;
    localparam logic [3:0] PH_VOFF = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    note_rsp_t        out_reg, out_next;
    logic             out_vld_reg, out_vld_next;
    logic             adv, emit;
    logic [7:0]       byte_c;

    assign adv   = !out_vld_reg || pop;
    assign emit  = adv && !cmd_empty;
    assign empty = !out_vld_reg;
    assign rsp   = out_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        byte_c     = ZERO_DELTA;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            PH_DLY:
            begin
                byte_c = vlq_byte(cmd.dly, cmd.dly_n, idx_reg);
                if (idx_reg == cmd.dly_n - CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = cmd.first ? PH_PC : PH_NOTE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            PH_PC:
            begin
                byte_c     = cmd.pc_status;
                state_next = PH_INST;
            end
            PH_INST:
            begin
                byte_c     = cmd.instrument;
                state_next = PH_ZERO;
            end
            PH_ZERO:
            begin
                byte_c     = ZERO_DELTA;
                state_next = PH_NON;
            end
            PH_NON:
            begin
                byte_c     = cmd.on_status;
                state_next = PH_NOTE;
            end
            PH_NOTE:
            begin
                byte_c     = cmd.note;
                state_next = PH_VEL;
            end
            PH_VEL:
            begin
                byte_c     = VEL_ON;
                state_next = PH_LEN;
            end
            PH_LEN:
            begin
                byte_c = vlq_byte(cmd.len, cmd.len_n, idx_reg);
                if (idx_reg == cmd.len_n - CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = PH_NOFF;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            PH_NOFF:
            begin
                byte_c     = cmd.note;
                state_next = PH_VOFF;
            end
            PH_VOFF:
            begin
                byte_c     = VEL_OFF;
                state_next = PH_DLY;
                cmd_pop    = emit;
            end
            default:
            begin
                state_next = PH_DLY;
                idx_next   = '0;
            end
        endcase
        if (!emit)
        begin
            state_next = state_reg;
            idx_next   = idx_reg;
        end
    end

    always_comb
    begin
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        if (adv)
        begin
            out_vld_next = emit;
            if (emit)
            begin
                out_next.out_byte = byte_c;
                out_next.last     = (state_reg == PH_VOFF);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= PH_DLY;
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

/* rtl/core/midi_note_event_encoder.sv */
// Note event encoder: turns one note request into its Standard MIDI File bytes.
// Request side: drive req and push; the request is taken on a clock edge with
//   push high and full low. The internal queue holds the request the sequencer
//   is working on plus one more classified request waiting behind it.
// Result side: while empty is low, rsp holds the oldest byte; it is taken on a
//   clock edge with pop high. rsp.last marks the final byte of a request.
// Each request yields 6 to 16 bytes: the delay delta (1-4 bytes), the optional
//   program change block (4 bytes), note and velocity, the length delta
//   (1-4 bytes), note and zero velocity.
// The request is first written into the queue; its first byte is then registered
//   into the output register before it shows on rsp. The output sequencer emits
//   one byte per cycle while pop keeps the output register free.
// A stalled pop holds the output register and the sequencer; the queue keeps
//   taking requests until it fills, then full rises.
// Reset clears the queue, the sequencer and the output valid flag.
module midi_note_event_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mnee_pkg::note_req_t req,
    output logic                empty,
    input  logic                pop,
    output mnee_pkg::note_rsp_t rsp
);
    import mnee_pkg::*;

    mnee_cmd_t cmd_in;
    mnee_cmd_t cmd_head;
    logic      q_empty;
    logic      q_pop;

    mnee_front u_front (
        .req (req),
        .cmd (cmd_in)
    );

    mnee_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (cmd_head),
        .empty   (q_empty)
    );

    mnee_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .rsp       (rsp),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
